FILE: rtl/core/blzd_pkg.sv
// Package with the shared types, constants and code tables of the backward LZ token decoder.
package blzd_pkg;

    localparam int LENGTH_BITS_DEFAULT = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int FILTER_DEFAULT_WORDS = 320 * 200 / 16;

    typedef enum logic [2:0] {
        PH_LITLEN = 3'd0,
        PH_LIT    = 3'd1,
        PH_WLEN   = 3'd2,
        PH_WDIST  = 3'd3,
        PH_FILT   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        KIND_LITERAL = 3'd0,
        KIND_MATCH   = 3'd1,
        KIND_FILTER  = 3'd2,
        KIND_DONE    = 3'd3,
        KIND_ERROR   = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_EOF_LITLEN = 4'd1,
        ERR_LIT_OVER   = 4'd2,
        ERR_EOF_LIT    = 4'd3,
        ERR_EOF_WLEN   = 4'd4,
        ERR_EOF_WDIST  = 4'd5,
        ERR_MATCH_OVER = 4'd6,
        ERR_DISTANCE   = 4'd7,
        ERR_EOF_FILT   = 4'd8,
        ERR_TRAILING   = 4'd9
    } err_t;

    localparam logic CFG_OUTPUT_LENGTH = 1'b0;
    localparam logic CFG_FILTER_MODE   = 1'b1;

    // One byte as queued between front and back.
    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } byte_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  literal_value;
        logic [10:0] match_length;
        logic [12:0] match_distance;
        logic [16:0] filter_length;
        err_t        error_code;
        logic        last;
    } result_t;

    function automatic logic [4:0] need_bits(input phase_t ph, input logic [2:0] s);
        logic [4:0] n;
        n = 5'd1;
        unique case (ph)
            PH_LITLEN:
            begin
                unique case (s)
                    3'd2, 3'd3: n = 5'd2;
                    3'd4: n = 5'd3;
                    3'd5: n = 5'd8;
                    3'd6: n = 5'd15;
                    default: n = 5'd1;
                endcase
            end
            PH_WLEN:
            begin
                unique case (s)
                    3'd5: n = 5'd2;
                    3'd6: n = 5'd10;
                    default: n = 5'd1;
                endcase
            end
            PH_WDIST:
            begin
                unique case (s)
                    3'd0: n = 5'd7;
                    3'd1: n = 5'd3;
                    3'd3: n = 5'd8;
                    3'd5: n = 5'd5;
                    3'd6: n = 5'd12;
                    default: n = 5'd1;
                endcase
            end
            default: n = (s == 3'd2) ? 5'd16 : 5'd1;
        endcase
        return n;
    endfunction

    function automatic logic [15:0] ll_add(input logic [2:0] s);
        logic [15:0] a;
        unique case (s)
            3'd1: a = 16'd1;
            3'd2: a = 16'd2;
            3'd3: a = 16'd5;
            3'd4: a = 16'd8;
            3'd5: a = 16'd15;
            3'd6: a = 16'd270;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

    // Value that escapes to the next, longer literal length code.
    function automatic logic [15:0] ll_esc(input logic [2:0] s);
        logic [15:0] e;
        unique case (s)
            3'd0: e = 16'd1;
            3'd1: e = 16'd2;
            3'd2: e = 16'd5;
            3'd3: e = 16'd8;
            3'd4: e = 16'd15;
            3'd5: e = 16'd270;
            default: e = 16'hFFFF;
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/core/blzd_if.sv
// Valid/ready stream interfaces of the decoder.
interface blzd_in_if;
    import blzd_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       final_byte;
    modport source (output valid, output stream_byte, output final_byte, input ready);
    modport sink (input valid, input stream_byte, input final_byte, output ready);
endinterface

interface blzd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  literal_value;
    logic [10:0] match_length;
    logic [12:0] match_distance;
    logic [16:0] filter_length;
    logic [3:0]  error_code;
    logic        last;
    modport source (output valid, output kind, output literal_value, output match_length,
                    output match_distance, output filter_length, output error_code,
                    output last, input ready);
    modport sink (input valid, input kind, input literal_value, input match_length,
                  input match_distance, input filter_length, input error_code,
                  input last, output ready);
endinterface

interface blzd_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [24:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/blzd_front.sv
// Front end: accepts stream bytes into a short queue.
module blzd_front
    import blzd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  flush,
    input  logic  in_valid,
    output logic  in_ready,
    input  byte_t in_byte,
    output logic  q_valid,
    input  logic  q_pop,
    output byte_t q_byte
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    byte_t         mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    logic          push;

    assign in_ready = (cnt_reg != (PW+1)'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_byte   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (flush)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (q_pop)
            begin
                rp_reg <= (rp_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(q_pop);
        end
    end
endmodule

FILE: rtl/core/blzd_back.sv
// Back end: bit buffer, code decoding, length bookkeeping and result output.
module blzd_back
    import blzd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_len_we,
    input  logic [24:0] cfg_len,
    input  logic        cfg_filt,
    input  logic        q_valid,
    output logic        q_pop,
    input  byte_t       q_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output result_t     res
);
    localparam logic [32:0] CAP = 33'd1 << LENGTH_BITS;

    logic [31:0] buf_reg, buf_next;
    logic [5:0]  cnt_reg, cnt_next;
    phase_t      ph_reg, ph_next;
    logic [2:0]  step_reg, step_next;
    logic [15:0] litleft_reg, litleft_next;
    logic [24:0] rem_reg, rem_next;
    logic [24:0] total_reg;
    logic [10:0] plen_reg, plen_next;
    logic [12:0] dpart_reg, dpart_next;
    logic        fin_reg, fin_next;
    // A byte is being worked on while busy_reg is set; eof_reg is its end mark.
    logic        busy_reg, busy_next;
    logic        eof_reg, eof_next;
    result_t     out_reg;
    logic        ov_reg;

    logic        emit;
    result_t     er;
    logic [24:0] capped;

    assign capped = ({8'd0, cfg_len} > CAP) ? CAP[24:0] : cfg_len;

    // An emitted result needs a free output register.
    logic out_free;
    assign out_free  = !ov_reg || res_ready;
    assign res_valid = ov_reg;
    assign res       = out_reg;

    always_comb
    begin
        logic [4:0]  k;
        logic [15:0] v;
        logic [15:0] val;
        logic [24:0] mdist;
        logic [24:0] written;
        logic [15:0] mlen;
        logic        endchk;
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        ph_next      = ph_reg;
        step_next    = step_reg;
        litleft_next = litleft_reg;
        rem_next     = rem_reg;
        plen_next    = plen_reg;
        dpart_next   = dpart_reg;
        fin_next     = fin_reg;
        busy_next    = busy_reg;
        eof_next     = eof_reg;
        emit         = 1'b0;
        er           = '{KIND_LITERAL, 8'd0, 11'd0, 13'd0, 17'd0, ERR_NONE, 1'b0};
        q_pop        = 1'b0;
        endchk       = 1'b0;
        k            = need_bits(ph_reg, step_reg);
        v            = 16'((buf_reg >> (6'd32 - {1'b0, k})) & ((32'd1 << k) - 32'd1));
        val          = '0;
        mdist        = '0;
        mlen         = '0;
        written      = total_reg - rem_reg;

        if (!busy_reg)
        begin
            // Fetch: once finished, bytes are dropped; a literal byte is emitted at once, else it fills the buffer.
            if (q_valid && (fin_reg || ph_reg != PH_LIT || out_free))
            begin
                q_pop = 1'b1;
                if (!fin_reg)
                begin
                    busy_next = 1'b1;
                    eof_next  = q_byte.eof;
                    if (ph_reg == PH_LIT)
                    begin
                        emit             = 1'b1;
                        er.kind          = KIND_LITERAL;
                        er.literal_value = q_byte.data;
                        if (rem_reg != '0)
                        begin
                            rem_next = rem_reg - 1'b1;
                        end
                        if (litleft_reg <= 16'd1)
                        begin
                            litleft_next = '0;
                            if (rem_reg <= 25'd1)
                            begin
                                endchk = 1'b1;
                            end
                            else
                            begin
                                ph_next   = PH_WLEN;
                                step_next = '0;
                            end
                        end
                        else
                        begin
                            litleft_next = litleft_reg - 1'b1;
                        end
                    end
                    else if (cnt_reg <= 6'd24)
                    begin
                        buf_next = buf_reg | ({24'd0, q_byte.data} << (6'd24 - cnt_reg));
                        cnt_next = cnt_reg + 6'd8;
                    end
                end
            end
        end
        else if (fin_reg)
        begin
            busy_next = 1'b0;
        end
        else if (out_free)
        begin
            // One code step per cycle while the output register is free.
            if (ph_reg == PH_FILT && step_reg == 3'd7)
            begin
                // Step seven of the filter phase is the pending end check.
                endchk = 1'b1;
            end
            else if (ph_reg == PH_LIT)
            begin
                busy_next = 1'b0;
                if (eof_reg)
                begin
                    emit = 1'b1; er.kind = KIND_ERROR; er.error_code = ERR_EOF_LIT;
                    er.last = 1'b1; fin_next = 1'b1;
                end
            end
            else if ({1'b0, cnt_reg} < {1'b0, k})
            begin
                busy_next = 1'b0;
                if (eof_reg)
                begin
                    emit = 1'b1; er.kind = KIND_ERROR; er.last = 1'b1; fin_next = 1'b1;
                    unique case (ph_reg)
                        PH_LITLEN: er.error_code = ERR_EOF_LITLEN;
                        PH_WLEN:   er.error_code = ERR_EOF_WLEN;
                        PH_WDIST:  er.error_code = ERR_EOF_WDIST;
                        default:   er.error_code = ERR_EOF_FILT;
                    endcase
                end
            end
            else
            begin
                buf_next = buf_reg << k;
                cnt_next = cnt_reg - {1'b0, k};
                unique case (ph_reg)
                    PH_LITLEN:
                    begin
                        val = v + ll_add(step_reg);
                        if (step_reg < 3'd6 && val == ll_esc(step_reg))
                        begin
                            step_next = step_reg + 1'b1;
                        end
                        else if ({9'd0, val} > rem_reg)
                        begin
                            emit = 1'b1; er.kind = KIND_ERROR; er.error_code = ERR_LIT_OVER;
                            er.last = 1'b1; fin_next = 1'b1;
                        end
                        else if (val == 16'd0)
                        begin
                            if (rem_reg == '0)
                            begin
                                endchk = 1'b1;
                            end
                            else
                            begin
                                ph_next = PH_WLEN; step_next = '0;
                            end
                        end
                        else
                        begin
                            litleft_next = val; ph_next = PH_LIT;
                        end
                    end
                    PH_WLEN:
                    begin
                        mlen = '0;
                        unique case (step_reg)
                            3'd0: if (v == 0) mlen = 16'd2; else step_next = 3'd1;
                            3'd1: if (v == 0) mlen = 16'd3; else step_next = 3'd2;
                            3'd2: step_next = (v == 0) ? 3'd3 : 3'd4;
                            3'd3: mlen = 16'd4 + v;
                            3'd4: step_next = (v == 0) ? 3'd5 : 3'd6;
                            3'd5: mlen = 16'd6 + v;
                            default: mlen = 16'd10 + v;
                        endcase
                        if (mlen != '0)
                        begin
                            plen_next = mlen[10:0];
                            ph_next   = PH_WDIST;
                            step_next = (mlen == 16'd2) ? 3'd0 : 3'd2;
                        end
                    end
                    PH_WDIST:
                    begin
                        mdist = '0;
                        unique case (step_reg)
                            3'd0:
                            begin
                                if (v + 16'd1 >= 16'd65)
                                begin
                                    dpart_next = 13'(v + 16'd1); step_next = 3'd1;
                                end
                                else
                                begin
                                    mdist = 25'(v) + 25'd1;
                                end
                            end
                            3'd1: mdist = ((25'(dpart_reg) - 25'd65) << 3) + 25'd65 + 25'(v);
                            3'd2: step_next = (v == 0) ? 3'd3 : 3'd4;
                            3'd3: mdist = 25'd33 + 25'(v);
                            3'd4: step_next = (v == 0) ? 3'd5 : 3'd6;
                            3'd5: mdist = 25'd1 + 25'(v);
                            default: mdist = 25'd289 + 25'(v);
                        endcase
                        if (mdist != '0)
                        begin
                            if (mdist > 25'd1)
                            begin
                                mdist = mdist + 25'(plen_reg) - 25'd2;
                            end
                            emit = 1'b1; er.last = 1'b0;
                            if (25'(plen_reg) > rem_reg)
                            begin
                                er.kind = KIND_ERROR; er.error_code = ERR_MATCH_OVER;
                                er.last = 1'b1; fin_next = 1'b1;
                            end
                            else if (mdist > written)
                            begin
                                er.kind = KIND_ERROR; er.error_code = ERR_DISTANCE;
                                er.last = 1'b1; fin_next = 1'b1;
                            end
                            else
                            begin
                                er.kind = KIND_MATCH;
                                er.match_length = plen_reg;
                                er.match_distance = mdist[12:0];
                                rem_next = rem_reg - 25'(plen_reg);
                                ph_next = PH_LITLEN; step_next = '0;
                            end
                        end
                    end
                    default:
                    begin
                        // Filter info goes out first; the end check follows in step seven.
                        if (step_reg == 3'd0)
                        begin
                            if (v[0] && !(eof_reg && cnt_next == '0))
                            begin
                                step_next = 3'd1;
                            end
                            else if (v[0])
                            begin
                                emit = 1'b1; er.kind = KIND_FILTER;
                                er.filter_length = 17'(FILTER_DEFAULT_WORDS);
                                step_next = 3'd7;
                            end
                            else
                            begin
                                endchk = 1'b1;
                            end
                        end
                        else if (step_reg == 3'd1)
                        begin
                            if (v[0])
                            begin
                                step_next = 3'd2;
                            end
                            else
                            begin
                                emit = 1'b1; er.kind = KIND_FILTER;
                                er.filter_length = 17'(FILTER_DEFAULT_WORDS);
                                step_next = 3'd7;
                            end
                        end
                        else
                        begin
                            emit = 1'b1; er.kind = KIND_FILTER;
                            er.filter_length = 17'(v) + 17'd1;
                            step_next = 3'd7;
                        end
                    end
                endcase
            end
        end

        if (endchk)
        begin
            if (cfg_filt && !(ph_reg == PH_FILT))
            begin
                ph_next = PH_FILT; step_next = '0;
                if (emit)
                begin
                    // The literal goes out now; the filter bits are read after it.
                    busy_next = 1'b1;
                end
            end
            else if (emit)
            begin
                // Literal emitted this cycle; run the end check afterwards.
                ph_next = PH_FILT; step_next = 3'd7;
            end
            else
            begin
                emit = 1'b1; er.last = 1'b1; fin_next = 1'b1;
                if (eof_reg && cnt_next == '0)
                begin
                    er.kind = KIND_DONE;
                end
                else
                begin
                    er.kind = KIND_ERROR; er.error_code = ERR_TRAILING;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= er;
        end
        litleft_reg <= litleft_next;
        plen_reg    <= plen_next;
        dpart_reg   <= dpart_next;
        eof_reg     <= eof_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= '0;
            cnt_reg   <= '0;
            ph_reg    <= PH_LITLEN;
            step_reg  <= '0;
            rem_reg   <= 25'd1;
            total_reg <= 25'd1;
            fin_reg   <= 1'b0;
            busy_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else if (cfg_len_we)
        begin
            buf_reg   <= '0;
            cnt_reg   <= '0;
            ph_reg    <= PH_LITLEN;
            step_reg  <= '0;
            rem_reg   <= capped;
            total_reg <= capped;
            fin_reg   <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            buf_reg  <= buf_next;
            cnt_reg  <= cnt_next;
            ph_reg   <= ph_next;
            step_reg <= step_next;
            rem_reg  <= rem_next;
            fin_reg  <= fin_next;
            busy_reg <= busy_next;
            if (emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end
endmodule

FILE: rtl/core/backward_lz_token_decoder.sv
// Top level of the backward LZ token decoder.
//  channel | dir | payload
//  in      | in  | stream_byte, final_byte
//  out     | out | kind, literal_value, match_length, match_distance, filter_length,
//          |     | error_code, last
//  cfg     | in  | index, data
// A literal byte is first fetched and emitted, then its end mark is checked.
// A control byte is first put into the buffer, then codes are decoded from it one per step
// until a step finds the buffer short; after a final literal the end check is a step of its own.
// Reset restarts the stream; a write to output_length restarts it too and empties the queue.
// The two-entry byte queue lets input run ahead while the output register is stalled.
module backward_lz_token_decoder
    import blzd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
    input logic clk,
    input logic rst_n,
    blzd_in_if.sink    in,
    blzd_out_if.source out,
    blzd_cfg_if.sink   cfg
);
    logic    len_we;
    logic    filt_reg;
    logic    q_valid, q_pop;
    byte_t   q_byte, in_b;
    result_t r;

    assign cfg.ready = 1'b1;
    assign len_we = cfg.valid && cfg.index == CFG_OUTPUT_LENGTH;
    assign in_b = '{in.stream_byte, in.final_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.index == CFG_FILTER_MODE)
        begin
            filt_reg <= cfg.data[0];
        end
    end

    logic [24:0] len_val;
    assign len_val = cfg.data;

    blzd_front u_front (
        .clk(clk), .rst_n(rst_n), .flush(len_we),
        .in_valid(in.valid), .in_ready(in.ready), .in_byte(in_b),
        .q_valid(q_valid), .q_pop(q_pop), .q_byte(q_byte)
    );

    blzd_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg_len_we(len_we), .cfg_len(len_val),
        .cfg_filt(filt_reg), .q_valid(q_valid), .q_pop(q_pop), .q_byte(q_byte),
        .res_valid(out.valid), .res_ready(out.ready), .res(r)
    );

    assign out.kind           = r.kind;
    assign out.literal_value  = r.literal_value;
    assign out.match_length   = r.match_length;
    assign out.match_distance = r.match_distance;
    assign out.filter_length  = r.filter_length;
    assign out.error_code     = r.error_code;
    assign out.last           = r.last;
endmodule

FILE: rtl/core/blzd_checker.sv
// Port-level checker of the decoder and its bind.
module blzd_checker
    import blzd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_kind,
    input logic [3:0]  out_error_code,
    input logic        out_last
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind))
        else $error("result dropped while stalled");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (out_kind == KIND_DONE || out_kind == KIND_ERROR)))
        else $error("last flag mismatch");
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_kind == KIND_ERROR) == (out_error_code != ERR_NONE)))
        else $error("error code mismatch");
endmodule

bind backward_lz_token_decoder blzd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out.valid), .out_ready(out.ready),
    .out_kind(out.kind), .out_error_code(out.error_code), .out_last(out.last)
);
